@@ sv/rti_pkg.sv @@
`default_nettype none
package rti_pkg;

    // component width of every field
    localparam int C_W = 16;
    // width of determinant and numerators
    localparam int NUM_W = 56;
    // quotient bits produced by the division pipe
    localparam int DIV_STEPS = 32;
    // fractional bits of the distance
    localparam int FRAC_BITS = 16;
    // sideband carried through the division pipe: miss, overflow, origin, direction
    localparam int SIDE_W = 2 + 6 * C_W;

    localparam logic [1:0] CFG_VERTEX_A = 2'd0;
    localparam logic [1:0] CFG_VERTEX_B = 2'd1;
    localparam logic [1:0] CFG_VERTEX_C = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [15:0] THR_RESET = 16'd7;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic               hit;
        logic [31:0]        distance;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic               overflow;
    } t_ray_out;

endpackage
`default_nettype wire

@@ sv/rti_div.sv @@
`default_nettype none
module rti_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [rti_pkg::NUM_W-1:0]     i_rem,
    input  wire logic [rti_pkg::NUM_W-1:0]     i_den,
    input  wire logic [rti_pkg::FRAC_BITS-1:0] i_low,
    input  wire logic [rti_pkg::SIDE_W-1:0]    i_side,
    output logic                               o_valid,
    output logic [rti_pkg::DIV_STEPS-1:0]      o_quo,
    output logic                               o_rem_nz,
    output logic [rti_pkg::SIDE_W-1:0]         o_side
);

    localparam int NW = rti_pkg::NUM_W;
    localparam int ST = rti_pkg::DIV_STEPS;

    logic          r_vld  [ST];
    logic [NW-1:0] r_rem  [ST];
    logic [NW-1:0] r_den  [ST];
    logic [ST-1:0] r_dig  [ST];
    logic [ST-1:0] r_quo  [ST];
    logic [rti_pkg::SIDE_W-1:0] r_side [ST];

    genvar k;
    generate
        for (k = 0; k < ST; k++) begin : g_step
            logic          p_vld;
            logic [NW-1:0] p_rem;
            logic [NW-1:0] p_den;
            logic [ST-1:0] p_dig;
            logic [ST-1:0] p_quo;
            logic [rti_pkg::SIDE_W-1:0] p_side;
            logic [NW:0]   trial;
            logic          take;
            logic [NW-1:0] n_rem;

            if (k == 0) begin : g_first
                assign p_vld  = i_valid;
                assign p_rem  = i_rem;
                assign p_den  = i_den;
                assign p_dig  = {i_low, {(ST - rti_pkg::FRAC_BITS){1'b0}}};
                assign p_quo  = '0;
                assign p_side = i_side;
            end else begin : g_next
                assign p_vld  = r_vld[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_den  = r_den[k-1];
                assign p_dig  = r_dig[k-1];
                assign p_quo  = r_quo[k-1];
                assign p_side = r_side[k-1];
            end

            // one restoring step: bring in the next dividend bit
            assign trial = {p_rem, p_dig[ST-1]};
            assign take  = (trial >= {1'b0, p_den});
            assign n_rem = take ? NW'(trial - {1'b0, p_den}) : NW'(trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_den[k]  <= p_den;
                    r_dig[k]  <= {p_dig[ST-2:0], 1'b0};
                    r_quo[k]  <= {p_quo[ST-2:0], take};
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_valid  = r_vld[ST-1];
    assign o_quo    = r_quo[ST-1];
    assign o_rem_nz = (r_rem[ST-1] != '0);
    assign o_side   = r_side[ST-1];

endmodule
`default_nettype wire

@@ sv/ray_triangle_intersect_top.sv @@
// ray against triangle intersection, fully pipelined
// an accepted word passes stages 1 to 5, the quotient pipe, the stage after division and the output stage
// throughput: one ray per cycle unless the output stalls; the 32-step quotient pipe sets the depth
// the whole pipe holds while a result word is stalled on the output
// reset (synchronous, active low) clears all valid bits, vertices to zero,
// threshold to 7
`default_nettype none
module ray_triangle_intersect_top #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire rti_pkg::t_ray_in  i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output rti_pkg::t_ray_out      o_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [47:0]       i_cfg_data
);

    // components wider than the 16-bit fields act as 16
    localparam int EW = (COORD_WIDTH < rti_pkg::C_W) ? COORD_WIDTH : rti_pkg::C_W;
    localparam int NW = rti_pkg::NUM_W;
    localparam int FB = rti_pkg::FRAC_BITS;

    function automatic logic signed [15:0] sx(input logic [15:0] v);
        logic signed [EW-1:0] t;
        t = v[EW-1:0];
        return 16'(t);
    endfunction

    // configuration registers
    logic [47:0] r_va, r_vb, r_vc;
    logic [15:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= '0;
            r_vb  <= '0;
            r_vc  <= '0;
            r_thr <= rti_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rti_pkg::CFG_VERTEX_A:  r_va  <= i_cfg_data;
                rti_pkg::CFG_VERTEX_B:  r_vb  <= i_cfg_data;
                rti_pkg::CFG_VERTEX_C:  r_vc  <= i_cfg_data;
                rti_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances unless a finished word is held on the output
    logic en;
    logic r_out_vld;
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // stage 1: unpack, edges e1 = b-a, e2 = c-a, s = origin-a
    logic signed [15:0] in_o [3];
    logic signed [15:0] in_d [3];
    logic signed [16:0] n_e1 [3];
    logic signed [16:0] n_e2 [3];
    logic signed [16:0] n_s  [3];

    always_comb begin
        logic signed [15:0] ca, cb, cc;
        in_o[0] = sx(i_data.origin_x);
        in_o[1] = sx(i_data.origin_y);
        in_o[2] = sx(i_data.origin_z);
        in_d[0] = sx(i_data.dir_x);
        in_d[1] = sx(i_data.dir_y);
        in_d[2] = sx(i_data.dir_z);
        for (int i = 0; i < 3; i++) begin
            ca = sx(r_va[16*i +: 16]);
            cb = sx(r_vb[16*i +: 16]);
            cc = sx(r_vc[16*i +: 16]);
            n_e1[i] = 17'(cb) - 17'(ca);
            n_e2[i] = 17'(cc) - 17'(ca);
            n_s[i]  = 17'(in_o[i]) - 17'(ca);
        end
    end

    logic               r1_vld;
    logic signed [16:0] r1_e1 [3];
    logic signed [16:0] r1_e2 [3];
    logic signed [16:0] r1_s  [3];
    logic signed [15:0] r1_o  [3];
    logic signed [15:0] r1_d  [3];

    // stage 2: h = dir x e2, q = s x e1
    logic signed [33:0] n_h [3];
    logic signed [34:0] n_q [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_h[i] = 34'(r1_d[(i+1)%3]) * 34'(r1_e2[(i+2)%3])
                   - 34'(r1_d[(i+2)%3]) * 34'(r1_e2[(i+1)%3]);
            n_q[i] = 35'(r1_s[(i+1)%3]) * 35'(r1_e1[(i+2)%3])
                   - 35'(r1_s[(i+2)%3]) * 35'(r1_e1[(i+1)%3]);
        end
    end

    logic               r2_vld;
    logic signed [16:0] r2_e1 [3];
    logic signed [16:0] r2_e2 [3];
    logic signed [16:0] r2_s  [3];
    logic signed [15:0] r2_o  [3];
    logic signed [15:0] r2_d  [3];
    logic signed [33:0] r2_h  [3];
    logic signed [34:0] r2_q  [3];

    // stage 3: the twelve dot-product terms
    logic               r3_vld;
    logic signed [NW-1:0] r3_pn [3];
    logic signed [NW-1:0] r3_pu [3];
    logic signed [NW-1:0] r3_pv [3];
    logic signed [NW-1:0] r3_pt [3];
    logic signed [15:0] r3_o [3];
    logic signed [15:0] r3_d [3];

    // stage 4: determinant n and numerators of u, v, t
    logic               r4_vld;
    logic signed [NW-1:0] r4_n, r4_un, r4_vn, r4_tn;
    logic signed [15:0] r4_o [3];
    logic signed [15:0] r4_d [3];

    // stage 5: sign fold and exact hit tests on numerators
    logic signed [NW-1:0] f_n, f_un, f_vn, f_tn;
    logic                 n_miss;

    always_comb begin
        if (r4_n < 0) begin
            f_n  = -r4_n;
            f_un = -r4_un;
            f_vn = -r4_vn;
            f_tn = -r4_tn;
        end else begin
            f_n  = r4_n;
            f_un = r4_un;
            f_vn = r4_vn;
            f_tn = r4_tn;
        end
        n_miss = (r4_n == '0)
              || (f_n < $signed({{(NW-24){1'b0}}, r_thr, 8'd0}))
              || (f_un < 0) || (f_un > f_n)
              || (f_vn < 0) || ((f_un + f_vn) > f_n)
              || (f_tn <= 0);
    end

    logic               r5_vld;
    logic               r5_miss;
    logic [NW-1:0]      r5_n;
    logic [NW-1:0]      r5_tn;
    logic signed [15:0] r5_o [3];
    logic signed [15:0] r5_d [3];

    // integer part of t at or above 65536 saturates
    logic                          div_ovf;
    logic [NW-1:0]                 div_rem;
    logic [rti_pkg::SIDE_W-1:0]    div_side;

    assign div_rem  = {{FB{1'b0}}, r5_tn[NW-1:FB]};
    assign div_ovf  = !r5_miss && (div_rem >= r5_n);
    assign div_side = {r5_miss, div_ovf, r5_o[0], r5_o[1], r5_o[2],
                       r5_d[0], r5_d[1], r5_d[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_e1[i] <= n_e1[i];
                r1_e2[i] <= n_e2[i];
                r1_s[i]  <= n_s[i];
                r1_o[i]  <= in_o[i];
                r1_d[i]  <= in_d[i];

                r2_e1[i] <= r1_e1[i];
                r2_e2[i] <= r1_e2[i];
                r2_s[i]  <= r1_s[i];
                r2_o[i]  <= r1_o[i];
                r2_d[i]  <= r1_d[i];
                r2_h[i]  <= n_h[i];
                r2_q[i]  <= n_q[i];

                r3_pn[i] <= NW'(r2_e1[i]) * NW'(r2_h[i]);
                r3_pu[i] <= NW'(r2_s[i])  * NW'(r2_h[i]);
                r3_pv[i] <= NW'(r2_d[i])  * NW'(r2_q[i]);
                r3_pt[i] <= NW'(r2_e2[i]) * NW'(r2_q[i]);
                r3_o[i]  <= r2_o[i];
                r3_d[i]  <= r2_d[i];

                r4_o[i]  <= r3_o[i];
                r4_d[i]  <= r3_d[i];

                r5_o[i]  <= r4_o[i];
                r5_d[i]  <= r4_d[i];
            end
            r4_n  <= r3_pn[0] + r3_pn[1] + r3_pn[2];
            r4_un <= r3_pu[0] + r3_pu[1] + r3_pu[2];
            r4_vn <= r3_pv[0] + r3_pv[1] + r3_pv[2];
            r4_tn <= r3_pt[0] + r3_pt[1] + r3_pt[2];

            r5_miss <= n_miss;
            r5_n    <= f_n;
            r5_tn   <= f_tn;
        end
    end

    // quotient pipe: t = tn / n as Q16.16, one bit per stage
    logic                       dv_vld;
    logic [31:0]                dv_quo;
    logic                       dv_rem_nz;
    logic [rti_pkg::SIDE_W-1:0] dv_side;

    rti_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r5_vld),
        .i_rem    (div_rem),
        .i_den    (r5_n),
        .i_low    (r5_tn[FB-1:0]),
        .i_side   (div_side),
        .o_valid  (dv_vld),
        .o_quo    (dv_quo),
        .o_rem_nz (dv_rem_nz),
        .o_side   (dv_side)
    );

    // stage after division: final hit decision, dir * t
    logic               dv_miss, dv_ovf;
    logic signed [15:0] dv_o [3];
    logic signed [15:0] dv_d [3];
    logic [31:0]        n_tq;
    logic               n_hit;

    always_comb begin
        dv_miss = dv_side[rti_pkg::SIDE_W-1];
        dv_ovf  = dv_side[rti_pkg::SIDE_W-2];
        for (int i = 0; i < 3; i++) begin
            dv_o[i] = dv_side[16*(5-i) +: 16];
            dv_d[i] = dv_side[16*(2-i) +: 16];
        end
        n_tq  = dv_ovf ? 32'hFFFF_FFFF : dv_quo;
        // distance must lie strictly beyond epsilon
        n_hit = !dv_miss && (dv_ovf || (dv_quo > 32'(r_thr))
                || ((dv_quo == 32'(r_thr)) && dv_rem_nz));
    end

    logic               r6_vld;
    logic               r6_hit, r6_ovf;
    logic [31:0]        r6_tq;
    logic signed [15:0] r6_o [3];
    logic signed [48:0] r6_pd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [48:0] tqs;
        tqs = {17'd0, n_tq};
        if (en) begin
            r6_hit <= n_hit;
            r6_ovf <= dv_ovf;
            r6_tq  <= n_tq;
            for (int i = 0; i < 3; i++) begin
                r6_o[i]  <= dv_o[i];
                r6_pd[i] <= 49'(dv_d[i]) * tqs;
            end
        end
    end

    // output stage: origin + dir*t, floor to Q24.8, saturate
    rti_pkg::t_ray_out  n_out;
    logic signed [31:0] pos  [3];
    logic               sat  [3];

    always_comb begin
        logic signed [49:0] p;
        logic signed [49:0] ps;
        for (int i = 0; i < 3; i++) begin
            p  = (50'(r6_o[i]) <<< 16) + 50'(r6_pd[i]);
            ps = p >>> 8;
            if ((ps[49:31] == '0) || (ps[49:31] == '1)) begin
                pos[i] = ps[31:0];
                sat[i] = 1'b0;
            end else begin
                pos[i] = ps[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                sat[i] = 1'b1;
            end
        end
        if (r6_hit) begin
            n_out.hit      = 1'b1;
            n_out.distance = r6_tq;
            n_out.hit_x    = pos[0];
            n_out.hit_y    = pos[1];
            n_out.hit_z    = pos[2];
            n_out.overflow = r6_ovf || sat[0] || sat[1] || sat[2];
        end else begin
            n_out = '0;
        end
    end

    rti_pkg::t_ray_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // a miss word carries all zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.hit) |-> (o_data == '0))
        else $error("miss word with nonzero fields");

    // overflow only on a hit
    a_ovf_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.overflow) |-> o_data.hit)
        else $error("overflow without hit");

    // a hit lies at or beyond epsilon
    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.hit) |-> (o_data.distance >= 32'(r_thr)))
        else $error("hit distance below threshold");

    // input stall only while a result word waits
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire
